[hdl/fat16_cluster_chain_manager_top_macros.svh]
// Assertion macros for the FAT16 chain manager
`ifndef FAT16_CLUSTER_CHAIN_MANAGER_TOP_MACROS_SVH
`define FAT16_CLUSTER_CHAIN_MANAGER_TOP_MACROS_SVH
// implication checked on every clock, masked in reset
`define FCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/fcm_pkg.sv]
// Shared types and codes for the FAT16 chain manager
`default_nettype none
package fcm_pkg;
  localparam logic [2:0] OP_FORMAT = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_WRITE  = 3'd4;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_MEDIA = 2'd1;
  localparam logic [1:0] REG_LOG2  = 2'd2;
  localparam logic [15:0] ENT_RSV0 = 16'hff00;
  localparam logic [15:0] ENT_EOC  = 16'hffff;
  localparam logic [15:0] ENT_FREE = 16'h0000;
endpackage
`default_nettype wire

[hdl/fat16_cluster_chain_manager_top.sv]
// From accept to result: write, bad index and no-op beats finish at the accept; read goes
// through S_RD and S_RDW; format writes each entry in turn up to the limit; allocate
// reads the end-of-chain code, scans for free entries and links each one taken; free
// walks and clears the chain, flagging a break; a failed allocate frees its partial chain.
// One beat at a time: the next input beat is taken the cycle after the result is accepted.
// Reset sets state, result flag and config registers; the table holds garbage until formatted.
`default_nettype none
module fat16_cluster_chain_manager_top #(
  parameter int MAX_CLUSTERS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] cluster,
  input  wire logic [31:0] length,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      first_cluster,
  output logic [15:0]      entry_value
);
  import fcm_pkg::*;
  `include "fat16_cluster_chain_manager_top_macros.svh"

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int NW = AW + 1;
  localparam logic [NW-1:0] MAXN = NW'(MAX_CLUSTERS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FMT   = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_RDW   = 11'b00000001000,
    S_EOC   = 11'b00000010000,
    S_EOCW  = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_SCANW = 11'b00010000000,
    S_LINK  = 11'b00100000000,
    S_FREE  = 11'b01000000000,
    S_FREEW = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [12:0] cluster_count;
  logic [7:0]  media_type;
  logic [4:0]  cluster_bytes_log2;
  logic [2:0]  op_q;
  logic [15:0] cl_q, eoc, cur, prev, head;
  logic [NW-1:0] idx, nlim, steps;
  logic [16:0] need, taken;
  logic        in_alloc;
  logic        res_valid;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;
  logic [4:0]  k;
  logic [32:0] need_w;

  fcm_table_ram #(.Depth(MAX_CLUSTERS), .AddrW(AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    nlim = (int'(cluster_count) > MAX_CLUSTERS) ? MAXN : NW'(cluster_count);
    if ({3'd0, cluster_count} < 16'd3) nlim = NW'(3);
    k = (cluster_bytes_log2 < 5'd9) ? 5'd9 :
        (cluster_bytes_log2 > 5'd16) ? 5'd16 : cluster_bytes_log2;
    need_w = ({1'b0, length} + ((33'd1 << k) - 33'd1)) >> k;
  end

  assign in_ready = (state == S_IDLE) && !res_valid;
  assign out_valid = res_valid;

  // memory port control
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx[AW-1:0];
    ram_wdata = ENT_FREE;
    case (state)
      S_IDLE: begin
        // raw entry write goes straight to the table on the accepting edge
        if (in_valid && in_ready && op == OP_WRITE && {1'b0, cluster} < 17'(nlim)) begin
          ram_we = 1'b1;
          ram_addr = cluster[AW-1:0];
          ram_wdata = value;
        end
      end
      S_FMT: begin
        ram_we = 1'b1;
        ram_wdata = (idx == '0) ? (ENT_RSV0 | {8'd0, media_type}) :
                    (idx == NW'(1)) ? ENT_EOC : ENT_FREE;
      end
      S_RD:   ram_addr = cl_q[AW-1:0];
      S_EOC:  ram_addr = AW'(1);
      S_SCAN: ram_addr = idx[AW-1:0];
      S_LINK: begin
        // first cluster of a chain has no predecessor to link from
        ram_we = (prev != '0);
        ram_addr = prev[AW-1:0];
        ram_wdata = cur;
      end
      S_FREE: ram_addr = cur[AW-1:0];
      S_FREEW: begin
        ram_we = 1'b1;
        ram_addr = cur[AW-1:0];
      end
      S_SCANW: begin
        ram_we = (ram_rdata == ENT_FREE) && (taken < need);
        ram_addr = idx[AW-1:0];
        ram_wdata = eoc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      cluster_count <= 13'd4096;
      media_type <= 8'd248;
      cluster_bytes_log2 <= 5'd9;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT: cluster_count <= cfg_data;
          REG_MEDIA: media_type <= cfg_data[7:0];
          REG_LOG2:  cluster_bytes_log2 <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (res_valid && out_ready) res_valid <= 1'b0;
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op_q <= op; cl_q <= cluster;
          status <= ST_OK; first_cluster <= '0; entry_value <= '0;
          idx <= '0; steps <= '0; taken <= '0; prev <= '0; head <= '0;
          in_alloc <= (op == OP_ALLOC);
          need <= need_w[16:0];
          cur <= cluster;
          case (op)
            OP_FORMAT: ;
            OP_ALLOC: begin
              if (length == 32'd0) res_valid <= 1'b1;
              else if (need_w > {16'd0, 17'(nlim) - 17'd2}) begin
                status <= ST_FULL; res_valid <= 1'b1;
              end
            end
            OP_READ, OP_WRITE: begin
              if ({1'b0, cluster} >= 17'(nlim)) begin
                status <= ST_BAD; res_valid <= 1'b1;
              end else if (op == OP_WRITE) res_valid <= 1'b1;
            end
            OP_FREE: ;
            default: res_valid <= 1'b1;
          endcase
        end
        S_FMT: begin
          idx <= idx + NW'(1);
          if (idx + NW'(1) >= nlim) res_valid <= 1'b1;
        end
        S_RDW: begin
          entry_value <= ram_rdata; res_valid <= 1'b1;
        end
        S_EOCW: begin
          eoc <= ram_rdata; idx <= NW'(2);
          if (op_q == OP_FREE && ram_rdata == cl_q) res_valid <= 1'b1;
        end
        S_SCANW: begin
          if (taken >= need) begin
            first_cluster <= head; res_valid <= 1'b1;
          end else if (ram_rdata == ENT_FREE) begin
            cur <= 16'(idx);
            if (prev == '0) head <= 16'(idx);
            taken <= taken + 17'd1;
            idx <= idx + NW'(1);
          end else idx <= idx + NW'(1);
        end
        S_SCAN: begin
          if (taken >= need) begin
            first_cluster <= head; res_valid <= 1'b1;
          end else if (idx >= nlim) begin
            status <= ST_FULL;
            cur <= head;
            if (head == eoc) res_valid <= 1'b1;
          end
        end
        S_LINK: prev <= cur;
        S_FREE: begin
          if (cur < 16'd2 || {1'b0, cur} >= 17'(nlim) || steps >= nlim) begin
            if (!in_alloc) status <= ST_BAD;
            res_valid <= 1'b1;
          end
        end
        S_FREEW: begin
          cur <= ram_rdata; steps <= steps + NW'(1);
          if (ram_rdata == eoc) res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        case (op)
          OP_FORMAT: state_next = S_FMT;
          OP_ALLOC: state_next = (length == 32'd0 ||
                      need_w > {16'd0, 17'(nlim) - 17'd2}) ? S_IDLE : S_EOC;
          OP_FREE: state_next = S_EOC;
          OP_READ: state_next = ({1'b0, cluster} >= 17'(nlim)) ? S_IDLE : S_RD;
          default: state_next = S_IDLE;
        endcase
      end
      S_FMT:  if (idx + NW'(1) >= nlim) state_next = S_IDLE;
      S_RD:   state_next = S_RDW;
      S_RDW:  state_next = S_IDLE;
      S_EOC:  state_next = S_EOCW;
      S_EOCW: state_next = (op_q == OP_ALLOC) ? S_SCAN :
                           (ram_rdata == cl_q) ? S_IDLE : S_FREE;
      S_SCAN: begin
        if (taken >= need) state_next = S_IDLE;
        else if (idx >= nlim) state_next = (head == eoc) ? S_IDLE : S_FREE;
        else state_next = S_SCANW;
      end
      S_SCANW: begin
        if (taken >= need) state_next = S_IDLE;
        else if (ram_rdata == ENT_FREE) state_next = (prev == '0) ? S_LINK : S_LINK;
        else state_next = S_SCAN;
      end
      S_LINK: state_next = S_SCAN;
      S_FREE: state_next = (cur < 16'd2 || {1'b0, cur} >= 17'(nlim) || steps >= nlim)
                           ? S_IDLE : S_FREEW;
      S_FREEW: state_next = (ram_rdata == eoc) ? S_IDLE : S_FREE;
      default: state_next = S_IDLE;
    endcase
  end

  `FCM_ASSERT_IMP(a_one_item, out_valid, !in_ready, "item accepted while result pending")
  `FCM_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
  `FCM_ASSERT_IMP(a_first_ok, out_valid && first_cluster != 16'd0, status == ST_OK,
                  "chain head reported with failure")
  `FCM_ASSERT_IMP(a_rd_value, out_valid && entry_value != 16'd0, op_q == OP_READ,
                  "entry value on non-read")
endmodule
`default_nettype wire

[hdl/fcm_table_ram.sv]
// Single-port synchronous table memory with registered read data
`default_nettype none
module fcm_table_ram #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] addr,
  input  wire logic [15:0]      wdata,
  output logic      [15:0]      rdata
);
  logic [15:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
